// ===== rtl/bfop_pkg.sv =====
// Package for the bounded FIFO with overflow policy.
// Holds default sizes, register indexes, command and mode codes, and the cell control type.
// No dependencies.
package bfop_pkg;

  localparam int unsigned DEPTH_DEFAULT     = 16;
  localparam int unsigned WORD_BITS_DEFAULT = 32;

  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 5;
  localparam int unsigned CAP_W      = 5;
  localparam int unsigned OCC_W      = 5;
  localparam int unsigned FLAGS_W    = 3;

  localparam logic [CFG_ADDR_W-1:0] REG_CAPACITY      = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_OVERFLOW_MODE = CFG_ADDR_W'(1);

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_e;

  typedef enum logic {
    MODE_DROP_OLDEST = 1'b0,
    MODE_REJECT      = 1'b1
  } mode_e;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    logic shift;  // every cell but the addressed one takes its upstream neighbor's word
    logic load;   // the addressed cell takes the pushed word
  } cell_ctl_t;

endpackage

// ===== rtl/bounded_fifo_overflow_policy.sv =====
// Bounded FIFO with drop-oldest or reject overflow policy, built as a shifting chain of cells.
// Each result transaction is registered and presented in the cycle after its input transaction is accepted.
// Throughput: one push or pop per cycle while the result is taken; the output register is reloaded as it drains.
// Reset clears count, output valid and config (capacity = 16, drop-oldest); cell words
// are not reset and are only read after being written. Depends on bfop_pkg, bfop_cell.
module bounded_fifo_overflow_policy #(
  parameter int unsigned DEPTH     = bfop_pkg::DEPTH_DEFAULT,
  parameter int unsigned WORD_BITS = bfop_pkg::WORD_BITS_DEFAULT,
  localparam int unsigned IN_TW    = ((WORD_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_BITS = WORD_BITS + bfop_pkg::OCC_W + 2,
  localparam int unsigned OUT_TW   = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [IN_TW-1:0]                  s_axis_tdata,   // push_word
  input  logic                              s_axis_tuser,   // command
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [OUT_TW-1:0]                 m_axis_tdata, // pop_word, occupancy, is_empty, is_full
  output logic [bfop_pkg::FLAGS_W-1:0]      m_axis_tuser,   // accepted, dropped_oldest, pop_valid
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bfop_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [bfop_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import bfop_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  // config
  logic [CAP_W-1:0] cap_q;
  mode_e            mode_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= CAP_RESET;
      mode_q <= MODE_DROP_OLDEST;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        REG_CAPACITY:      cap_q  <= cfg_data_i[CAP_W-1:0];
        REG_OVERFLOW_MODE: mode_q <= mode_e'(cfg_data_i[0]);
        default: ;
      endcase
    end
  end

  logic [CW-1:0] cap_ext, cap_eff;

  always_comb begin
    cap_ext = CW'(cap_q);
    cap_eff = cap_ext;
    if (cap_ext == '0) begin
      cap_eff = CW'(1);
    end else if (cap_ext > CW'(DEPTH)) begin
      cap_eff = CW'(DEPTH);
    end
  end

  // control
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 s_fire, full, nonempty;
  cmd_e                 cmd;
  logic [WORD_BITS-1:0] push_word;
  logic [WORD_BITS-1:0] front_word;
  cell_ctl_t            ctl;
  logic [IDX_W-1:0]     load_idx;
  logic                 accepted, dropped, pop_valid;

  assign s_fire    = s_axis_tvalid && s_axis_tready;
  assign cmd       = cmd_e'(s_axis_tuser);
  assign push_word = s_axis_tdata[WORD_BITS-1:0];
  assign full      = CW'(cnt_q) >= cap_eff;
  assign nonempty  = cnt_q != '0;

  always_comb begin
    cnt_d     = cnt_q;
    ctl       = '0;
    load_idx  = cnt_q[IDX_W-1:0];
    accepted  = 1'b0;
    dropped   = 1'b0;
    pop_valid = 1'b0;
    if (s_fire) begin
      case (cmd)
        CMD_PUSH: begin
          if (!full) begin
            ctl.load = 1'b1;
            cnt_d    = cnt_q + CNT_W'(1);
            accepted = 1'b1;
          end else if (mode_q == MODE_DROP_OLDEST && nonempty) begin
            ctl.load  = 1'b1;
            ctl.shift = 1'b1;
            load_idx  = IDX_W'(cnt_q - CNT_W'(1));
            accepted  = 1'b1;
            dropped   = 1'b1;
          end
        end
        CMD_POP: begin
          if (nonempty) begin
            ctl.shift = 1'b1;
            cnt_d     = cnt_q - CNT_W'(1);
            pop_valid = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // cell chain, cell 0 is the front
  logic [WORD_BITS-1:0] chain_word [DEPTH+1];

  assign chain_word[DEPTH] = '0;
  assign front_word        = chain_word[0];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    bfop_cell #(
      .WORD_BITS (WORD_BITS),
      .IDX_W     (IDX_W),
      .IDX       (i)
    ) u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .load_idx_i  (load_idx),
      .push_word_i (push_word),
      .next_word_i (chain_word[i+1]),
      .word_o      (chain_word[i])
    );
  end

  // output register
  logic                  out_valid_q;
  logic [OUT_TW-1:0]     out_data_q, out_data_d;
  logic [FLAGS_W-1:0]    out_user_q, out_user_d;
  logic [CW-1:0]         occ_ext;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign occ_ext       = CW'(cnt_d);

  always_comb begin
    out_data_d = '0;
    if (pop_valid) begin
      out_data_d[WORD_BITS-1:0] = front_word;
    end
    out_data_d[WORD_BITS +: OCC_W] = occ_ext[OCC_W-1:0];
    out_data_d[WORD_BITS + OCC_W]     = (cnt_d == '0);
    out_data_d[WORD_BITS + OCC_W + 1] = (occ_ext >= cap_eff);
    out_user_d = {pop_valid, dropped, accepted};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      out_data_q <= out_data_d;
      out_user_q <= out_user_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_fire_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> m_axis_tvalid)
    else $error("transaction produced no result");

  a_drop_implies_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (!m_axis_tuser[1] || m_axis_tuser[0]) &&
                      !(m_axis_tuser[0] && m_axis_tuser[2]))
    else $error("inconsistent result flags");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && cmd == CMD_PUSH && !full |=> cnt_q == $past(cnt_q) + CNT_W'(1))
    else $error("push into non-full queue did not grow count");

  a_drop_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && dropped |=> cnt_q == $past(cnt_q))
    else $error("drop-oldest push changed count");

endmodule

// ===== rtl/bfop_cell.sv =====
// One storage cell of the FIFO chain: holds a word, shifts toward the front.
// Depends on bfop_pkg for the cell control type.
module bfop_cell #(
  parameter int unsigned WORD_BITS = bfop_pkg::WORD_BITS_DEFAULT,
  parameter int unsigned IDX_W     = 4,
  parameter int unsigned IDX       = 0
) (
  input  logic                  clk_i,
  input  bfop_pkg::cell_ctl_t   ctl_i,
  input  logic [IDX_W-1:0]      load_idx_i,
  input  logic [WORD_BITS-1:0]  push_word_i,
  input  logic [WORD_BITS-1:0]  next_word_i,
  output logic [WORD_BITS-1:0]  word_o
);
  import bfop_pkg::*;

  logic [WORD_BITS-1:0] word_q, word_d;
  logic                 hit;

  assign hit = ctl_i.load && (load_idx_i == IDX_W'(IDX));

  always_comb begin
    word_d = word_q;
    if (hit) begin
      word_d = push_word_i;
    end else if (ctl_i.shift) begin
      word_d = next_word_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

// ===== tb/tb_bounded_fifo_overflow_policy.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for bounded_fifo_overflow_policy: directed table, then random phases.
// Each result is checked against the table's typed result or an in-bench FIFO model. Depends on bfop_pkg and the RTL.
module tb_bounded_fifo_overflow_policy;
  import bfop_pkg::*;

  localparam int unsigned FIFO_DEPTH = DEPTH_DEFAULT;
  localparam int unsigned WB         = WORD_BITS_DEFAULT;
  localparam int          IDLE_LIMIT = 4000;
  localparam int          NUM_PHASES = 16;
  localparam int          PHASE_ITEMS = 106;

  typedef struct packed {
    logic          is_full;
    logic          is_empty;
    logic [OCC_W-1:0] occupancy;
    logic [WB-1:0] pop_word;
    logic          pop_valid;
    logic          dropped_oldest;
    logic          accepted;
  } fifo_res_t;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_e;

  typedef struct packed {
    row_kind_e               kind;
    cmd_e                    cmd;
    logic [WB-1:0]           word;
    logic [CFG_ADDR_W-1:0]   addr;
    logic [CFG_DATA_W-1:0]   value;
    logic                    typed;
    fifo_res_t               want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [WB-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [FLAGS_W-1:0] m_axis_tuser;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_ADDR_W-1:0] cfg_addr_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  bounded_fifo_overflow_policy dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_addr_i, .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  // FIFO model state
  logic [WB-1:0]    store_q [FIFO_DEPTH];
  int unsigned      head_q = 0;
  int unsigned      tail_q = 0;
  int unsigned      fill_q = 0;
  logic [CAP_W-1:0] cap_q = CAP_RESET;
  mode_e            mode_q = MODE_DROP_OLDEST;

  fifo_res_t pending_res_q[$];
  int        mismatches = 0;
  int        send_idle_pct = 0;
  int        rx_stall_pct = 0;
  int        rx_hold = 0;
  int        idle_cycles = 0;

  function automatic fifo_res_t fifo_step(cmd_e cmd, logic [WB-1:0] w);
    fifo_res_t   r;
    int unsigned lim;
    r = '0;
    lim = (cap_q == 0) ? 1 : ((cap_q > FIFO_DEPTH) ? FIFO_DEPTH : cap_q);
    if (cmd == CMD_PUSH) begin
      if (fill_q < lim) begin
        store_q[tail_q] = w;
        tail_q = (tail_q + 1) % FIFO_DEPTH;
        fill_q++;
        r.accepted = 1'b1;
      end else if (mode_q == MODE_DROP_OLDEST && fill_q > 0) begin
        head_q = (head_q + 1) % FIFO_DEPTH;
        store_q[tail_q] = w;
        tail_q = (tail_q + 1) % FIFO_DEPTH;
        r.accepted = 1'b1;
        r.dropped_oldest = 1'b1;
      end
    end else if (fill_q > 0) begin
      r.pop_valid = 1'b1;
      r.pop_word = store_q[head_q];
      head_q = (head_q + 1) % FIFO_DEPTH;
      fill_q--;
    end
    r.occupancy = OCC_W'(fill_q);
    r.is_empty = (fill_q == 0);
    r.is_full = (fill_q >= lim);
    return r;
  endfunction

  function automatic fifo_res_t res(logic acc, logic drop, logic pv, logic [WB-1:0] pw,
                                    logic [OCC_W-1:0] occ, logic emp, logic full);
    fifo_res_t r;
    r.accepted = acc;
    r.dropped_oldest = drop;
    r.pop_valid = pv;
    r.pop_word = pw;
    r.occupancy = occ;
    r.is_empty = emp;
    r.is_full = full;
    return r;
  endfunction

  function automatic stim_row_t op_row(cmd_e cmd, logic [WB-1:0] w, logic typed,
                                       fifo_res_t want);
    stim_row_t row;
    row = '0;
    row.kind = ROW_ITEM;
    row.cmd = cmd;
    row.word = w;
    row.typed = typed;
    row.want = want;
    return row;
  endfunction

  function automatic stim_row_t reg_row(logic [CFG_ADDR_W-1:0] a, logic [CFG_DATA_W-1:0] v);
    stim_row_t row;
    row = '0;
    row.kind = ROW_REG;
    row.addr = a;
    row.value = v;
    return row;
  endfunction

  // Offer one transaction; returns at the accepting rising edge.
  task automatic send_item(cmd_e cmd, logic [WB-1:0] w, logic typed, fifo_res_t want);
    fifo_res_t r;
    @(negedge clk_i);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = w;
    s_axis_tuser = cmd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    r = fifo_step(cmd, w);
    pending_res_q.push_back(typed ? want : r);
  endtask

  task automatic halt_input();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_res_q.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_ADDR_W-1:0] a, logic [CFG_DATA_W-1:0] v);
    wait_drained();
    cfg_valid_i = 1'b1;
    cfg_addr_i = a;
    cfg_data_i = v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (a == REG_CAPACITY) cap_q = v;
    else if (a == REG_OVERFLOW_MODE) mode_q = mode_e'(v[0]);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  always @(negedge clk_i) begin
    if (rx_hold > 0) begin
      m_axis_tready = 1'b0;
      rx_hold--;
    end else begin
      m_axis_tready = ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    fifo_res_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.accepted = m_axis_tuser[0];
      got.dropped_oldest = m_axis_tuser[1];
      got.pop_valid = m_axis_tuser[2];
      got.pop_word = m_axis_tdata[WB-1:0];
      got.occupancy = m_axis_tdata[WB +: OCC_W];
      got.is_empty = m_axis_tdata[WB + OCC_W];
      got.is_full = m_axis_tdata[WB + OCC_W + 1];
      if (pending_res_q.size() == 0) begin
        if (mismatches < 10) $display("unexpected result transaction at %0t", $time);
        mismatches++;
      end else begin
        want = pending_res_q.pop_front();
        if (got !== want) begin
          if (mismatches < 10)
            $display("mismatch at %0t: acc %b/%b drop %b/%b pv %b/%b word %h/%h occ %0d/%0d emp %b/%b full %b/%b (exp/act)",
                     $time, want.accepted, got.accepted, want.dropped_oldest,
                     got.dropped_oldest, want.pop_valid, got.pop_valid, want.pop_word,
                     got.pop_word, want.occupancy, got.occupancy, want.is_empty,
                     got.is_empty, want.is_full, got.is_full);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t   stim_tab[$];
    stim_row_t   row;
    int          caps [NUM_PHASES];
    int          push_pct;
    int          burst;
    int          sel;
    cmd_e        cmd;
    logic [WB-1:0] w;

    caps = '{16, 1, 31, 0, 17, 4, 2, 8, 16, 3, 1, 12, 31, 5, 16, 7};

    // after reset: capacity 16, drop oldest
    stim_tab.push_back(op_row(CMD_POP, '0, 1'b1, res(0, 0, 0, '0, 0, 1, 0)));
    stim_tab.push_back(op_row(CMD_PUSH, '1, 1'b1, res(1, 0, 0, '0, 1, 0, 0)));
    stim_tab.push_back(op_row(CMD_PUSH, '0, 1'b0, '0));
    stim_tab.push_back(op_row(CMD_POP, '0, 1'b1, res(0, 0, 1, '1, 1, 0, 0)));
    stim_tab.push_back(op_row(CMD_POP, '0, 1'b0, '0));
    stim_tab.push_back(reg_row(REG_CAPACITY, 5'd1));
    stim_tab.push_back(op_row(CMD_PUSH, 32'hA5A5A5A5, 1'b1, res(1, 0, 0, '0, 1, 0, 1)));
    stim_tab.push_back(op_row(CMD_PUSH, 32'h5A5A5A5A, 1'b1, res(1, 1, 0, '0, 1, 0, 1)));
    stim_tab.push_back(reg_row(REG_OVERFLOW_MODE, 5'd1));
    stim_tab.push_back(op_row(CMD_PUSH, 32'h12345678, 1'b1, res(0, 0, 0, '0, 1, 0, 1)));
    stim_tab.push_back(op_row(CMD_POP, '0, 1'b1, res(0, 0, 1, 32'h5A5A5A5A, 0, 1, 0)));
    // zero capacity acts as one
    stim_tab.push_back(reg_row(REG_CAPACITY, 5'd0));
    stim_tab.push_back(op_row(CMD_PUSH, 32'h1, 1'b0, '0));
    stim_tab.push_back(op_row(CMD_PUSH, 32'h2, 1'b0, '0));
    // capacity above depth saturates; upper data bits ignored for the mode
    stim_tab.push_back(reg_row(REG_CAPACITY, 5'd31));
    stim_tab.push_back(reg_row(REG_OVERFLOW_MODE, 5'b11110));
    stim_tab.push_back(op_row(CMD_PUSH, 32'h3, 1'b0, '0));
    stim_tab.push_back(op_row(CMD_PUSH, 32'h4, 1'b0, '0));
    stim_tab.push_back(op_row(CMD_PUSH, 32'h5, 1'b0, '0));
    // capacity lowered below the count
    stim_tab.push_back(reg_row(REG_CAPACITY, 5'd2));
    stim_tab.push_back(op_row(CMD_PUSH, 32'h6, 1'b0, '0));
    stim_tab.push_back(reg_row(REG_OVERFLOW_MODE, 5'd1));
    stim_tab.push_back(op_row(CMD_PUSH, 32'h7, 1'b0, '0));
    // unknown register indexes are ignored
    stim_tab.push_back(reg_row(2'd2, 5'd31));
    stim_tab.push_back(reg_row(2'd3, 5'd0));
    repeat (5) stim_tab.push_back(op_row(CMD_POP, '0, 1'b0, '0));

    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (stim_tab[i]) begin
      row = stim_tab[i];
      if (row.kind == ROW_REG) begin
        halt_input();
        cfg_write(row.addr, row.value);
      end else begin
        send_item(row.cmd, row.word, row.typed, row.want);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      halt_input();
      case (p % 4)
        0: begin send_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin send_idle_pct = 82; rx_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  rx_stall_pct = 82; end
        default: begin send_idle_pct = 28; rx_stall_pct = 28; end
      endcase
      cfg_write(REG_CAPACITY, CFG_DATA_W'(caps[p]));
      cfg_write(REG_OVERFLOW_MODE, CFG_DATA_W'(p[0] ^ p[2]));
      burst = 0;
      push_pct = 50;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (burst == 0) begin
          burst = $urandom_range(40, 4);
          sel = $urandom_range(3);
          push_pct = (sel == 0) ? 25 : (sel == 1) ? 50 : (sel == 2) ? 75 : 90;
        end
        burst--;
        if (p == 3 && n == 10) rx_hold = 80;
        if (p == 5 && n == 50) begin
          halt_input();
          wait_drained();
        end
        cmd = ($urandom_range(99) < push_pct) ? CMD_PUSH : CMD_POP;
        sel = $urandom_range(15);
        w = (sel == 0) ? '0 : (sel == 1) ? '1 : WB'($urandom);
        send_item(cmd, w, 1'b0, '0);
      end
    end

    halt_input();
    wait_drained();
    repeat (5) @(negedge clk_i);
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
